FILE: design/aoc_pkg.sv
// ----------------------------------------------------------------------------
// aoc_pkg
// Types, constants and the rounded 8-bit multiply shared by the compositor.
// ----------------------------------------------------------------------------
package aoc_pkg;

    localparam int unsigned NUM_COLOURS = 3;
    localparam logic [7:0]  FULL_ALPHA  = 8'd255;
    localparam logic [7:0]  OPACITY_RST = 8'd255;
    localparam logic [16:0] ROUND_BIAS  = 17'd128;

    // One channel of the restoring divider.
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] lo;
        logic [7:0] quo;
        logic       sat;
    } div_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    // Rounded product a*b/255 in the form (t + (t >> 8)) >> 8, t = a*b + 128.
    function automatic logic [7:0] mul255(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] p;
        logic [16:0] t;
        logic [16:0] s;
        p = a * b;
        t = {1'b0, p} + ROUND_BIAS;
        s = t + {8'd0, t[16:8]};
        return s[15:8];
    endfunction

    function automatic logic [7:0] sat8(input logic [8:0] v);
        return v[8] ? FULL_ALPHA : v[7:0];
    endfunction

endpackage

FILE: design/aoc_in_if.sv
// ----------------------------------------------------------------------------
// aoc_in_if
// Input channel: one source and one destination pixel per word.
// ----------------------------------------------------------------------------
interface aoc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;

    modport source (output valid, src_red, src_green, src_blue, src_alpha,
                    dst_red, dst_green, dst_blue, dst_alpha, input ready);
    modport sink (input valid, src_red, src_green, src_blue, src_alpha,
                  dst_red, dst_green, dst_blue, dst_alpha, output ready);
endinterface

FILE: design/aoc_out_if.sv
// ----------------------------------------------------------------------------
// aoc_out_if
// Output channel: one composited pixel per word.
// ----------------------------------------------------------------------------
interface aoc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

FILE: design/aoc_cfg_if.sv
// ----------------------------------------------------------------------------
// aoc_cfg_if
// Configuration write channel carrying the global opacity.
// ----------------------------------------------------------------------------
interface aoc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: design/alpha_over_compositor_top.sv
// ----------------------------------------------------------------------------
// alpha_over_compositor_top
// Source-over compositing of straight-alpha 8-bit RGBA pixels.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the output is not stalled, each
// holding a source and a destination pixel, and returns one composited pixel
// per word, in order. It is an eight-stage pipeline: opacity scaling, the
// rounded products, the blend sums, the division set-up and four stages of a
// restoring divider that settle two quotient bits each. The whole
// pipeline advances together whenever the output register is empty or being
// emptied, so a stall at the output freezes every stage and nothing is lost or
// repeated. The global opacity resets to 255 and is written over the
// configuration channel, which is always ready; it should only be changed
// while no pixel is in flight.
module alpha_over_compositor_top
    import aoc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    aoc_in_if.sink    in_pix,
    aoc_out_if.source out_pix,
    aoc_cfg_if.sink   cfg
);

    localparam int unsigned DEPTH = 8;

    logic [7:0]       opacity_reg;
    logic [DEPTH:1]   valid_reg;
    logic             adv;

    // Stage 1: inputs and effective source alpha.
    logic [7:0] s1_src_reg [NUM_COLOURS];
    logic [7:0] s1_dst_reg [NUM_COLOURS];
    logic [7:0] s1_ea_reg;
    logic [7:0] s1_da_reg;
    logic [7:0] s1_ea_next;

    // Stage 2: products and bypass decision.
    logic [7:0] s2_ms_reg  [NUM_COLOURS];
    logic [7:0] s2_md_reg  [NUM_COLOURS];
    logic [7:0] s2_ea_reg;
    logic [7:0] s2_inv_reg;
    logic [7:0] s2_mda_reg;

    // Bypass pixels and flags travel alongside, stage 2 to stage 8.
    pixel_t     byp_reg  [2:DEPTH];
    logic       bypf_reg [2:DEPTH];
    pixel_t     byp_next;
    logic       bypf_next;

    // Stage 3: blend sums and combined alpha.
    logic [7:0] s3_v_reg [NUM_COLOURS];
    logic [7:0] s3_ca_reg;
    logic [7:0] ca_sat;

    // Stage 4 onwards: divider.
    div_t       div_d  [4:DEPTH][NUM_COLOURS];
    logic [7:0] div_ca [4:DEPTH];
    div_t       s4_next [NUM_COLOURS];

    assign adv          = !valid_reg[DEPTH] || out_pix.ready;
    assign in_pix.ready = adv;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg <= OPACITY_RST;
            valid_reg   <= '0;
        end
        else
        begin
            if (cfg.valid)
                opacity_reg <= cfg.data;
            if (adv)
                valid_reg <= {valid_reg[DEPTH-1:1], in_pix.valid};
        end
    end

    // Scaling is skipped for full opacity or a transparent source.
    assign s1_ea_next = (opacity_reg != FULL_ALPHA && in_pix.src_alpha != 8'd0)
                        ? mul255(in_pix.src_alpha, opacity_reg) : in_pix.src_alpha;

    always_comb
    begin
        logic copy_src;
        copy_src  = (s1_ea_reg == FULL_ALPHA) || (s1_da_reg == 8'd0 && s1_ea_reg != 8'd0);
        bypf_next = copy_src || (s1_ea_reg == 8'd0);
        if (copy_src)
            byp_next = '{red: s1_src_reg[0], green: s1_src_reg[1],
                         blue: s1_src_reg[2], alpha: s1_ea_reg};
        else
            byp_next = '{red: s1_dst_reg[0], green: s1_dst_reg[1],
                         blue: s1_dst_reg[2], alpha: s1_da_reg};
    end

    always_comb
    begin
        logic [8:0] ca_sum;
        ca_sum = {1'b0, s2_ea_reg} + {1'b0, s2_mda_reg};
        ca_sat = sat8(ca_sum);
        if (ca_sat == 8'd0)
            ca_sat = 8'd1;
    end

    // Division set-up: N = v * 255; a quotient of 256 or more saturates.
    always_comb
    begin
        for (int c = 0; c < NUM_COLOURS; c++)
        begin
            logic [15:0] n;
            n = {s3_v_reg[c], 8'd0} - {8'd0, s3_v_reg[c]};
            s4_next[c].rem = n[15:8];
            s4_next[c].lo  = n[7:0];
            s4_next[c].quo = '0;
            s4_next[c].sat = n[15:8] >= s3_ca_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_src_reg <= '{in_pix.src_red, in_pix.src_green, in_pix.src_blue};
            s1_dst_reg <= '{in_pix.dst_red, in_pix.dst_green, in_pix.dst_blue};
            s1_ea_reg  <= s1_ea_next;
            s1_da_reg  <= in_pix.dst_alpha;

            for (int c = 0; c < NUM_COLOURS; c++)
            begin
                s2_ms_reg[c] <= mul255(s1_src_reg[c], s1_ea_reg);
                s2_md_reg[c] <= mul255(s1_dst_reg[c], s1_da_reg);
            end
            s2_ea_reg  <= s1_ea_reg;
            s2_inv_reg <= FULL_ALPHA - s1_ea_reg;
            s2_mda_reg <= mul255(s1_da_reg, FULL_ALPHA - s1_ea_reg);
            byp_reg[2]  <= byp_next;
            bypf_reg[2] <= bypf_next;

            for (int c = 0; c < NUM_COLOURS; c++)
                s3_v_reg[c] <= sat8({1'b0, s2_ms_reg[c]}
                                    + {1'b0, mul255(s2_md_reg[c], s2_inv_reg)});
            s3_ca_reg <= ca_sat;

            div_d[4]  <= s4_next;
            div_ca[4] <= s3_ca_reg;

            for (int k = 3; k <= DEPTH; k++)
            begin
                byp_reg[k]  <= byp_reg[k-1];
                bypf_reg[k] <= bypf_reg[k-1];
            end
        end
    end

    // Stages 5 to 8: two quotient bits per stage.
    for (genvar g = 5; g <= DEPTH; g++)
    begin : g_div
        aoc_div_stage u_div (
            .clk    (clk),
            .en     (adv),
            .ca_in  (div_ca[g-1]),
            .d_in   (div_d[g-1]),
            .ca_out (div_ca[g]),
            .d_out  (div_d[g])
        );
    end

    always_comb
    begin
        out_pix.valid = valid_reg[DEPTH];
        if (bypf_reg[DEPTH])
        begin
            out_pix.out_red   = byp_reg[DEPTH].red;
            out_pix.out_green = byp_reg[DEPTH].green;
            out_pix.out_blue  = byp_reg[DEPTH].blue;
            out_pix.out_alpha = byp_reg[DEPTH].alpha;
        end
        else
        begin
            out_pix.out_red   = div_d[DEPTH][0].sat ? FULL_ALPHA : div_d[DEPTH][0].quo;
            out_pix.out_green = div_d[DEPTH][1].sat ? FULL_ALPHA : div_d[DEPTH][1].quo;
            out_pix.out_blue  = div_d[DEPTH][2].sat ? FULL_ALPHA : div_d[DEPTH][2].quo;
            out_pix.out_alpha = div_ca[DEPTH];
        end
    end

endmodule

FILE: design/aoc_div_stage.sv
// ----------------------------------------------------------------------------
// aoc_div_stage
// Two restoring division steps for every colour channel, registered.
// ----------------------------------------------------------------------------
module aoc_div_stage
    import aoc_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] ca_in,
    input  div_t       d_in  [NUM_COLOURS],
    output logic [7:0] ca_out,
    output div_t       d_out [NUM_COLOURS]
);

    div_t d_next [NUM_COLOURS];

    always_comb
    begin
        for (int c = 0; c < NUM_COLOURS; c++)
        begin
            d_next[c] = d_in[c];
            for (int s = 0; s < 2; s++)
            begin
                logic [8:0] r9;
                logic [8:0] diff;
                r9   = {d_next[c].rem, d_next[c].lo[7]};
                diff = r9 - {1'b0, ca_in};
                d_next[c].lo = {d_next[c].lo[6:0], 1'b0};
                if (r9 >= {1'b0, ca_in})
                begin
                    d_next[c].rem = diff[7:0];
                    d_next[c].quo = {d_next[c].quo[6:0], 1'b1};
                end
                else
                begin
                    d_next[c].rem = r9[7:0];
                    d_next[c].quo = {d_next[c].quo[6:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_out <= ca_in;
            d_out  <= d_next;
        end
    end

endmodule
